// ===== rtl/isqrt_pkg.sv =====
// shared types and constants for the integer square root block
package isqrt_pkg;

	// default radicand width and fixed root port width
	localparam int DEF_RADICAND_BITS = 64;
	localparam int ROOT_BITS         = 32;

	// sequencer states
	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} state_t;

	// per-cycle control broadcast to the cell row and the remainder unit
	typedef struct packed {
		logic load;
		logic shift;
	} cell_ctrl_t;

endpackage

// ===== rtl/isqrt_cell.sv =====
// one cell of the row: holds a radicand bit pair and one root bit
module isqrt_cell (
	input  logic                 clk,
	input  isqrt_pkg::cell_ctrl_t ctrl,
	input  logic [1:0]           load_pair,
	input  logic [1:0]           pair_in,
	input  logic                 root_in,
	output logic [1:0]           pair_out,
	output logic                 root_out
);
	import isqrt_pkg::*;

	logic [1:0] pair_q;
	logic       root_q;

	// load a new radicand pair or take data from the lower neighbor
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			pair_q <= load_pair;
			root_q <= 1'b0;
		end else if (ctrl.shift) begin
			pair_q <= pair_in;
			root_q <= root_in;
		end
	end

	assign pair_out = pair_q;
	assign root_out = root_q;

endmodule

// ===== rtl/isqrt_rem.sv =====
// remainder unit: brings down a bit pair and decides one root bit
module isqrt_rem #(
	parameter int PAIRS = 32
) (
	input  logic                  clk,
	input  isqrt_pkg::cell_ctrl_t ctrl,
	input  logic [1:0]            pair,
	input  logic [PAIRS-1:0]      root_part,
	output logic                  root_bit
);
	import isqrt_pkg::*;

	localparam int REM_W = PAIRS + 1;
	localparam int EXT_W = PAIRS + 3;

	logic [REM_W-1:0] rem_q;
	logic [EXT_W-1:0] shifted;
	logic [EXT_W-1:0] trial;
	logic [EXT_W-1:0] diff;

	// trial subtract of (4*root + 1) from the shifted remainder
	always_comb begin
		shifted  = {rem_q, pair};
		trial    = {1'b0, root_part, 2'b01};
		diff     = shifted - trial;
		root_bit = (shifted >= trial);
	end

	// remainder register, cleared on a new transaction
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			rem_q <= '0;
		end else if (ctrl.shift) begin
			if (root_bit) begin
				rem_q <= diff[REM_W-1:0];
			end else begin
				rem_q <= shifted[REM_W-1:0];
			end
		end
	end

endmodule

// ===== rtl/integer_square_root.sv =====
// integer square root top level: sequencer, cell row and output register
//
// Floor square root of an unsigned radicand, restoring method in radix 2.
// Input channel: in_valid / in_stall carry one radicand per transaction;
// only the low RADICAND_BITS bits are used, higher bits are ignored.
// Output channel: out_valid / out_stall carry one root per transaction.
// A row of PAIRS = (RADICAND_BITS+1)/2 cells holds the radicand bit pairs
// and the root bits; each cycle the row shifts by one cell while the
// remainder unit produces one root bit, except while the last step is
// held for a stalled output. One transaction is in work at a time: the
// result is registered at the last step and a new radicand is taken in
// the cycle after, when the sequencer is idle again.
// The output register lets a new radicand enter while the previous root
// still waits; if the receiver stalls, the last step of the next item is
// held until the output register is free, and in_stall stays high.
// Reset clears the sequencer and the output valid; in_stall is low after
// reset.
module integer_square_root #(
	parameter int RADICAND_BITS = isqrt_pkg::DEF_RADICAND_BITS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [63:0]                    radicand,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [isqrt_pkg::ROOT_BITS-1:0] root
);
	import isqrt_pkg::*;

	localparam int PAIRS = (RADICAND_BITS + 1) / 2;
	localparam int PAD_W = 2 * PAIRS;
	localparam int CNT_W = $clog2(PAIRS + 1);

	state_t           state_q, state_d;
	logic [CNT_W-1:0] cnt_q;
	logic             out_valid_q;
	logic [PAIRS-1:0] root_res_q;

	logic             accept;
	logic             out_free;
	logic             last;
	logic             finish;
	cell_ctrl_t       ctrl;
	logic [PAD_W-1:0] x_pad;
	logic [1:0]       pair_w [PAIRS];
	logic [PAIRS-1:0] root_vec;
	logic             new_bit;
	logic [PAIRS:0]   root_ext;

	// radicand masked to the configured width and padded to whole pairs
	assign x_pad = PAD_W'(radicand[RADICAND_BITS-1:0]);

	// handshake and step control
	always_comb begin
		in_stall   = (state_q != ST_IDLE);
		accept     = in_valid && !in_stall;
		out_free   = !out_valid_q || !out_stall;
		last       = (cnt_q == '0);
		ctrl.load  = accept;
		ctrl.shift = (state_q == ST_RUN) && (!last || out_free);
		finish     = (state_q == ST_RUN) && last && out_free;
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_RUN;
				end
			end
			ST_RUN: begin
				if (finish) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// state register and step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				cnt_q <= CNT_W'(PAIRS - 1);
			end else if (ctrl.shift && !last) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	// row of cells, pairs move toward the top, root bits enter at cell 0
	for (genvar i = 0; i < PAIRS; i++) begin : g_cell
		logic [1:0] pair_in_w;
		logic       root_in_w;

		if (i == 0) begin : g_first
			assign pair_in_w = 2'b00;
			assign root_in_w = new_bit;
		end else begin : g_next
			assign pair_in_w = pair_w[i-1];
			assign root_in_w = root_vec[i-1];
		end

		isqrt_cell u_cell (
			.clk       (clk),
			.ctrl      (ctrl),
			.load_pair (x_pad[2*i +: 2]),
			.pair_in   (pair_in_w),
			.root_in   (root_in_w),
			.pair_out  (pair_w[i]),
			.root_out  (root_vec[i])
		);
	end

	// remainder unit fed from the top cell
	isqrt_rem #(
		.PAIRS (PAIRS)
	) u_rem (
		.clk       (clk),
		.ctrl      (ctrl),
		.pair      (pair_w[PAIRS-1]),
		.root_part (root_vec),
		.root_bit  (new_bit)
	);

	// complete root including the bit decided in the final step
	assign root_ext = {root_vec, new_bit};

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (finish) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			root_res_q <= root_ext[PAIRS-1:0];
		end
	end

	assign out_valid = out_valid_q;
	assign root      = ROOT_BITS'(root_res_q);

endmodule
